### rtl/two_register_stack_vm_step_unit_assert.svh
// Assertion macros used by the stack machine step unit.
`ifndef TWO_REGISTER_STACK_VM_STEP_UNIT_ASSERT_SVH
`define TWO_REGISTER_STACK_VM_STEP_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TSVM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define TSVM_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### rtl/tsvm_pkg.sv
package tsvm_pkg;

  // Stack size and derived widths
  localparam int STACK_DEPTH = 4096;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int OP_W        = 8;
  localparam int DEPTH_NOW_W = 13;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SP_W-1:0]   sp_t;
  typedef logic [OP_W-1:0]   op_t;

  localparam sp_t SP_FULL = SP_W'(STACK_DEPTH);

  // Instruction bytes
  localparam op_t OP_DUMP      = 8'h30;
  localparam op_t OP_ADD       = 8'h31;
  localparam op_t OP_SUB       = 8'h32;
  localparam op_t OP_CMP       = 8'h33;
  localparam op_t OP_PUSH_REG  = 8'h34;
  localparam op_t OP_PUSH_IMM  = 8'h35;
  localparam op_t OP_POP_FIRST = 8'h36;
  localparam op_t OP_POP_SECND = 8'h37;
  localparam op_t OP_COPY      = 8'h38;
  localparam op_t OP_TEXT      = 8'h39;

  // Program position advance
  localparam word_t POS_STEP     = 32'd1;
  localparam word_t POS_STEP_IMM = 32'd5;

  typedef enum logic [1:0] {
    KIND_DUMP      = 2'd0,
    KIND_TEXT      = 2'd1,
    KIND_OVERFLOW  = 2'd2,
    KIND_UNDERFLOW = 2'd3
  } kind_t;

  // Shift control for the stack chain
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  // One result beat
  typedef struct packed {
    kind_t                  kind;
    word_t                  first_value;
    word_t                  second_value;
    word_t                  position;
    logic [DEPTH_NOW_W-1:0] depth_now;
    logic                   zero_out;
  } result_t;

endpackage

### rtl/tsvm_if.sv
// Instruction channel
interface tsvm_instr_if;
  logic                 valid;
  logic                 ready;
  tsvm_pkg::op_t        operation;
  tsvm_pkg::word_t      immediate;

  modport source (output valid, output operation, output immediate, input ready);
  modport sink   (input valid, input operation, input immediate, output ready);
endinterface

// Result channel
interface tsvm_result_if;
  logic                                 valid;
  logic                                 ready;
  tsvm_pkg::kind_t                      kind;
  tsvm_pkg::word_t                      first_value;
  tsvm_pkg::word_t                      second_value;
  tsvm_pkg::word_t                      position;
  logic [tsvm_pkg::DEPTH_NOW_W-1:0]     depth_now;
  logic                                 zero_out;

  modport source (output valid, output kind, output first_value, output second_value,
                  output position, output depth_now, output zero_out, input ready);
  modport sink   (input valid, input kind, input first_value, input second_value,
                  input position, input depth_now, input zero_out, output ready);
endinterface

### rtl/two_register_stack_vm_step_unit.sv
// Executes one instruction of the two-register stack machine per accepted beat, one
// beat per cycle while instr.ready is high: every opcode, pops included, finishes
// in the cycle it is accepted, since the stack is a row of STACK_DEPTH shift cells
// whose first cell always holds the top word. Dump, text output, overflow and
// underflow produce a result beat through a two-entry output buffer; instr.ready
// falls only while both entries hold results not yet taken. No clearing pass is needed
// after reset: stack words below the pointer are always ones written by a push.
`include "two_register_stack_vm_step_unit_assert.svh"

module two_register_stack_vm_step_unit (
  input  logic        clk,
  input  logic        rst,
  tsvm_instr_if.sink  instr,
  tsvm_result_if.source result
);

  tsvm_pkg::word_t      first_reg, first_next;
  tsvm_pkg::word_t      second_reg, second_next;
  tsvm_pkg::word_t      pos, pos_next;
  tsvm_pkg::sp_t        sp, sp_next;
  logic                 flag, flag_next;

  tsvm_pkg::stack_ctl_t ctl_raw, stack_ctl;
  tsvm_pkg::word_t      push_data;
  tsvm_pkg::word_t      stack_top;
  logic                 has_res;
  tsvm_pkg::kind_t      res_kind;
  tsvm_pkg::result_t    res_new;
  logic                 full, empty;
  logic                 accept;

  tsvm_pkg::result_t    out_q, skid_q;
  logic                 out_valid, skid_valid;
  logic                 take, load;

  assign accept = instr.valid && instr.ready;
  assign full   = (sp == tsvm_pkg::SP_FULL);
  assign empty  = (sp == '0);

  // Decode and execute the instruction
  always_comb begin
    first_next  = first_reg;
    second_next = second_reg;
    pos_next    = pos + tsvm_pkg::POS_STEP;
    sp_next     = sp;
    flag_next   = flag;
    ctl_raw     = '0;
    push_data   = first_reg;
    has_res     = 1'b0;
    res_kind    = tsvm_pkg::KIND_DUMP;
    case (instr.operation)
      tsvm_pkg::OP_DUMP: begin
        has_res = 1'b1;
      end
      tsvm_pkg::OP_ADD: first_next = first_reg + second_reg;
      tsvm_pkg::OP_SUB: first_next = first_reg - second_reg;
      tsvm_pkg::OP_CMP: flag_next = (first_reg == second_reg);
      tsvm_pkg::OP_PUSH_REG, tsvm_pkg::OP_PUSH_IMM: begin
        if (instr.operation == tsvm_pkg::OP_PUSH_IMM) begin
          pos_next  = pos + tsvm_pkg::POS_STEP_IMM;
          push_data = instr.immediate;
        end
        if (full) begin
          has_res  = 1'b1;
          res_kind = tsvm_pkg::KIND_OVERFLOW;
        end else begin
          ctl_raw.push = 1'b1;
          sp_next      = sp + tsvm_pkg::sp_t'(1);
        end
      end
      tsvm_pkg::OP_POP_FIRST, tsvm_pkg::OP_POP_SECND: begin
        if (empty) begin
          has_res  = 1'b1;
          res_kind = tsvm_pkg::KIND_UNDERFLOW;
        end else begin
          ctl_raw.pop = 1'b1;
          sp_next     = sp - tsvm_pkg::sp_t'(1);
          if (instr.operation == tsvm_pkg::OP_POP_FIRST) begin
            first_next = stack_top;
          end else begin
            second_next = stack_top;
          end
        end
      end
      tsvm_pkg::OP_COPY: second_next = first_reg;
      tsvm_pkg::OP_TEXT: begin
        has_res  = 1'b1;
        res_kind = tsvm_pkg::KIND_TEXT;
      end
      default: ;
    endcase
  end

  // Gate the stack shift with the handshake
  assign stack_ctl.push = accept && ctl_raw.push;
  assign stack_ctl.pop  = accept && ctl_raw.pop;

  tsvm_stack u_stack (
    .clk       (clk),
    .ctl       (stack_ctl),
    .push_data (push_data),
    .top       (stack_top)
  );

  // Machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_reg  <= '0;
      second_reg <= '0;
      pos        <= '0;
      sp         <= '0;
      flag       <= 1'b0;
    end else if (accept) begin
      first_reg  <= first_next;
      second_reg <= second_next;
      pos        <= pos_next;
      sp         <= sp_next;
      flag       <= flag_next;
    end
  end

  // Emitting opcodes change nothing but the program position, so report current values
  always_comb begin
    res_new.kind         = res_kind;
    res_new.first_value  = first_reg;
    res_new.second_value = second_reg;
    res_new.position     = pos;
    res_new.depth_now    = tsvm_pkg::DEPTH_NOW_W'(sp);
    res_new.zero_out     = flag;
  end

  // Two-entry output buffer: output register plus skid
  assign take = out_valid && result.ready;
  assign load = accept && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= load;
        end
      end else if (load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_q <= skid_valid ? skid_q : res_new;
    end
    if (out_valid && !take && load) begin
      skid_q <= res_new;
    end
  end

  assign instr.ready         = !skid_valid;
  assign result.valid        = out_valid;
  assign result.kind         = out_q.kind;
  assign result.first_value  = out_q.first_value;
  assign result.second_value = out_q.second_value;
  assign result.position     = out_q.position;
  assign result.depth_now    = out_q.depth_now;
  assign result.zero_out     = out_q.zero_out;

  // Checks
  `TSVM_ASSERT(a_sp_range, sp <= tsvm_pkg::SP_FULL, "stack pointer beyond depth")
  `TSVM_ASSERT(a_skid_order, !skid_valid || out_valid, "skid holds a beat ahead of output")
  `TSVM_ASSERT_NEXT(a_push_grows, accept && ctl_raw.push, sp == $past(sp) + tsvm_pkg::sp_t'(1), "push did not grow stack")
  `TSVM_ASSERT_NEXT(a_full_holds, accept && full && (instr.operation == tsvm_pkg::OP_PUSH_REG || instr.operation == tsvm_pkg::OP_PUSH_IMM), $stable(sp) && out_valid, "overflow changed stack or lost result")

endmodule

### rtl/tsvm_cell.sv
module tsvm_cell (
  input  logic                 clk,
  input  tsvm_pkg::stack_ctl_t ctl,
  input  tsvm_pkg::word_t      above,
  input  tsvm_pkg::word_t      below,
  output tsvm_pkg::word_t      value
);

  tsvm_pkg::word_t word;

  // Shift down on push, up on pop, hold otherwise
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word <= above;
    end else if (ctl.pop) begin
      word <= below;
    end
  end

  assign value = word;

endmodule

### rtl/tsvm_stack.sv
module tsvm_stack (
  input  logic                 clk,
  input  tsvm_pkg::stack_ctl_t ctl,
  input  tsvm_pkg::word_t      push_data,
  output tsvm_pkg::word_t      top
);

  tsvm_pkg::word_t cell_value [tsvm_pkg::STACK_DEPTH];

  // Row of cells, top of stack in cell 0
  for (genvar i = 0; i < tsvm_pkg::STACK_DEPTH; i++) begin : g_cell
    tsvm_pkg::word_t above;
    tsvm_pkg::word_t below;

    if (i == 0) begin : g_first
      assign above = push_data;
    end else begin : g_inner
      assign above = cell_value[i-1];
    end

    if (i == tsvm_pkg::STACK_DEPTH - 1) begin : g_last
      assign below = cell_value[i];
    end else begin : g_mid
      assign below = cell_value[i+1];
    end

    tsvm_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .value (cell_value[i])
    );
  end

  assign top = cell_value[0];

endmodule

### tb/tsvm_step_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the step unit, runs its own copy of the machine on every
// accepted instruction and compares each result beat against the oldest prediction.
module tsvm_step_checker
  import tsvm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  tsvm_instr_if  instr,
  tsvm_result_if result,
  output int     fail_count,
  output int     pending
);

  // Shadow machine state
  word_t   first_reg;
  word_t   second_reg;
  word_t   prog_pos;
  sp_t     words_held;
  logic    zero_flag;
  word_t   stack_words [STACK_DEPTH];
  result_t due_results [$];
  int      mismatches = 0;

  // Report one field that differs
  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Run one instruction on the shadow machine and queue the beat it should cause
  task automatic execute_instruction(input op_t op, input word_t imm);
    word_t   start_pos;
    logic    emits;
    kind_t   kind;
    result_t beat;
    start_pos = prog_pos;
    emits     = 1'b0;
    kind      = KIND_DUMP;
    prog_pos  = start_pos + ((op == OP_PUSH_IMM) ? POS_STEP_IMM : POS_STEP);
    case (op)
      OP_DUMP: emits = 1'b1;
      OP_ADD: first_reg = first_reg + second_reg;
      OP_SUB: first_reg = first_reg - second_reg;
      OP_CMP: zero_flag = (first_reg == second_reg);
      OP_PUSH_REG, OP_PUSH_IMM: begin
        if (words_held == SP_FULL) begin
          emits = 1'b1;
          kind  = KIND_OVERFLOW;
        end else begin
          stack_words[words_held] = (op == OP_PUSH_IMM) ? imm : first_reg;
          words_held = words_held + 1'b1;
        end
      end
      OP_POP_FIRST, OP_POP_SECND: begin
        if (words_held == '0) begin
          emits = 1'b1;
          kind  = KIND_UNDERFLOW;
        end else begin
          // decrement first, then read the top word
          words_held = words_held - 1'b1;
          if (op == OP_POP_FIRST)
            first_reg = stack_words[words_held];
          else
            second_reg = stack_words[words_held];
        end
      end
      OP_COPY: second_reg = first_reg;
      OP_TEXT: begin
        emits = 1'b1;
        kind  = KIND_TEXT;
      end
      default: ;
    endcase
    if (emits) begin
      beat.kind         = kind;
      beat.first_value  = first_reg;
      beat.second_value = second_reg;
      beat.position     = start_pos;
      beat.depth_now    = DEPTH_NOW_W'(words_held);
      beat.zero_out     = zero_flag;
      due_results.push_back(beat);
    end
  endtask

  // Compare one result beat field by field with the oldest prediction
  task automatic check_result_beat();
    result_t want;
    int      bad;
    if (due_results.size() == 0) begin
      $error("result beat with nothing predicted: kind %0d position 0x%0h",
             result.kind, result.position);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      bad  = field_mismatch("kind", want.kind, result.kind);
      bad += field_mismatch("first_value", want.first_value, result.first_value);
      bad += field_mismatch("second_value", want.second_value, result.second_value);
      bad += field_mismatch("position", want.position, result.position);
      bad += field_mismatch("depth_now", want.depth_now, result.depth_now);
      bad += field_mismatch("zero_out", want.zero_out, result.zero_out);
      mismatches += bad;
    end
  endtask

  // Retire results first, then predict from the instruction taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      first_reg  = '0;
      second_reg = '0;
      prog_pos   = '0;
      words_held = '0;
      zero_flag  = 1'b0;
      due_results.delete();
    end else begin
      if (result.valid && result.ready)
        check_result_beat();
      if (instr.valid && instr.ready)
        execute_instruction(instr.operation, instr.immediate);
    end
    fail_count <= mismatches;
    pending    <= due_results.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import tsvm_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int CALM_ITEMS     = 150;
  localparam int BACKLOG_ITEMS  = 30;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk;
  logic rst;

  tsvm_instr_if  instr_ch ();
  tsvm_result_if result_ch ();

  int fail_count;
  int pending;

  // Stimulus-side bookkeeping
  int words_on_stack = 0;
  bit calm           = 1'b0;
  bit long_hold_req  = 1'b0;
  bit holding        = 1'b0;

  op_t all_ops [10] = '{OP_DUMP, OP_ADD, OP_SUB, OP_CMP, OP_PUSH_REG, OP_PUSH_IMM,
                        OP_POP_FIRST, OP_POP_SECND, OP_COPY, OP_TEXT};

  two_register_stack_vm_step_unit dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  tsvm_step_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .instr      (instr_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one instruction, with an occasional idle burst ahead of it
  task automatic send_instr(input op_t op, input word_t imm);
    if (!calm && $urandom_range(0, 4) == 0) begin
      instr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    instr_ch.valid     <= 1'b1;
    instr_ch.operation <= op;
    instr_ch.immediate <= imm;
    do @(posedge clk); while (!instr_ch.ready);
    if ((op == OP_PUSH_REG || op == OP_PUSH_IMM) && words_on_stack < STACK_DEPTH)
      words_on_stack++;
    else if ((op == OP_POP_FIRST || op == OP_POP_SECND) && words_on_stack > 0)
      words_on_stack--;
  endtask

  // Result side: random stalls, ready runs, and one long hold on request
  initial begin : result_side
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req && !holding) begin
        result_ch.ready <= 1'b0;
        holding = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // End the run if no beat moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    do begin
      @(posedge clk);
      if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
        idle = 0;
      else
        idle++;
    end while (idle < WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    op_t   op;
    int    pick;
    int    n;
    rst                <= 1'b1;
    instr_ch.valid     <= 1'b0;
    instr_ch.operation <= '0;
    instr_ch.immediate <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: every opcode, wraps, equal and unequal compare, empty pops, stray bytes
    send_instr(OP_DUMP, $urandom());
    send_instr(OP_POP_FIRST, $urandom());
    send_instr(OP_POP_SECND, $urandom());
    send_instr(OP_PUSH_IMM, 32'hFFFF_FFFF);
    send_instr(OP_PUSH_IMM, 32'h0000_0000);
    send_instr(OP_POP_SECND, $urandom());
    send_instr(OP_POP_FIRST, $urandom());
    send_instr(OP_CMP, $urandom());
    send_instr(OP_TEXT, $urandom());
    send_instr(OP_PUSH_IMM, 32'h0000_0001);
    send_instr(OP_POP_SECND, $urandom());
    send_instr(OP_ADD, $urandom());
    send_instr(OP_SUB, $urandom());
    send_instr(OP_COPY, $urandom());
    send_instr(OP_CMP, $urandom());
    send_instr(OP_PUSH_REG, $urandom());
    send_instr(OP_DUMP, $urandom());
    send_instr(OP_POP_FIRST, $urandom());
    send_instr(8'h00, $urandom());
    send_instr(8'hFF, $urandom());
    send_instr(8'h2F, $urandom());
    send_instr(8'h3A, $urandom());
    send_instr(OP_TEXT, $urandom());
    send_instr(OP_DUMP, $urandom());

    // Fill the stack to the top, then push past it
    while (words_on_stack < STACK_DEPTH)
      send_instr(($urandom_range(0, 4) == 0) ? OP_PUSH_REG : OP_PUSH_IMM, $urandom());
    send_instr(OP_PUSH_REG, $urandom());
    send_instr(OP_PUSH_IMM, $urandom());
    send_instr(OP_DUMP, $urandom());

    // Drain it again, dumping now and then to expose the popped words
    n = 0;
    while (words_on_stack > 0) begin
      send_instr(($urandom_range(0, 1) == 0) ? OP_POP_FIRST : OP_POP_SECND, $urandom());
      n++;
      if (n % 16 == 0)
        send_instr(($urandom_range(0, 1) == 0) ? OP_DUMP : OP_TEXT, $urandom());
    end
    send_instr(OP_POP_FIRST, $urandom());
    send_instr(OP_DUMP, $urandom());

    // Backlog: hold the result side off and keep offering result-producing beats
    long_hold_req = 1'b1;
    wait (holding);
    repeat (BACKLOG_ITEMS)
      send_instr(($urandom_range(0, 1) == 0) ? OP_DUMP : OP_TEXT, $urandom());

    // Random mix, mostly well-formed stack traffic
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8)
        op = op_t'($urandom_range(0, 255));
      else if (pick < 30)
        op = ($urandom_range(0, 1) == 0) ? OP_PUSH_IMM : OP_PUSH_REG;
      else if (pick < 50) begin
        op = ($urandom_range(0, 1) == 0) ? OP_POP_FIRST : OP_POP_SECND;
        // mostly avoid pops on an empty stack
        if (words_on_stack == 0 && $urandom_range(0, 3) != 0)
          op = OP_PUSH_IMM;
      end else
        op = all_ops[$urandom_range(0, 9)];
      send_instr(op, ($urandom_range(0, 9) == 0) ? word_t'(0) : word_t'($urandom()));
    end
    instr_ch.valid <= 1'b0;

    // Wait out the remaining results, then a short quiet stretch
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tsvm_pkg.sv
rtl/tsvm_if.sv
rtl/tsvm_cell.sv
rtl/tsvm_stack.sv
rtl/two_register_stack_vm_step_unit.sv
tb/tsvm_step_checker.sv
tb/tb.sv
